### sv/pnr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnr_pkg
// types, register map and arithmetic helpers for the polynomial root finder
// ----------------------------------------------------------------------------
package pnr_pkg;

	localparam int XW = 32;

	typedef enum logic [1:0] {
		CAUSE_STEP  = 2'd0,
		CAUSE_FLAT  = 2'd1,
		CAUSE_LIMIT = 2'd2
	} cause_t;

	typedef enum logic [2:0] {
		REG_C0    = 3'd0,
		REG_C1    = 3'd1,
		REG_C2    = 3'd2,
		REG_C3    = 3'd3,
		REG_C4    = 3'd4,
		REG_TERMS = 3'd5,
		REG_TOL   = 3'd6,
		REG_LIMIT = 3'd7
	} reg_idx_t;

	// saturate a 64-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh7fffffff) r = 32'sh7fffffff;
		else if (v < -64'sh80000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage : pnr_pkg
`default_nettype wire

### sv/polynomial_newton_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_newton_root
// newton-raphson root search on a polynomial of up to five terms, q16.16
// ----------------------------------------------------------------------------
// One guess at a time. Each iteration runs Horner evaluation of p(x) and p'(x)
// through one shared 32x32 multiplier, one product per cycle, then a restoring
// division for p/p'. An iteration seeds, runs the Horner steps, tests the
// slope, runs the divider and updates x; an iteration that stops on a flat
// slope ends after the test. The iteration limit bounds the iterations a
// guess takes. start_guess_ready is low from the accepted item until its
// result is taken. Registers sit on an APB port at byte address 4*i.
module polynomial_newton_root
	import pnr_pkg::*;
#(
	parameter int MAX_TERMS = 5
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               start_guess_valid,
	output logic                    start_guess_ready,
	input  wire logic signed [31:0] start_guess,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic signed [31:0]      root_estimate,
	output logic [1:0]              stop_cause,
	output logic [15:0]             iterations_used
);
	localparam int TW = $clog2(MAX_TERMS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_INIT  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_TEST  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_STEP  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic signed [31:0] coef_q [MAX_TERMS];
	logic [2:0]  terms_q;
	logic [30:0] tol_q;
	logic [15:0] limit_q;

	logic signed [31:0] x_q, fx_q, dx_q;
	logic [TW-1:0] k_q, n_q;
	logic          phase_q;   // 0 multiply for p, 1 multiply for p'
	logic [15:0]   iter_q;
	logic          div_start, div_done;
	logic signed [63:0] quo;
	logic signed [63:0] div_num;

	assign pready = 1'b1;

	// config
	logic wr;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TERMS; i++) coef_q[i] <= '0;
			terms_q <= 3'd5;
			tol_q   <= 31'd66;
			limit_q <= 16'd100;
		end else if (wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_TERMS: terms_q <= pwdata[2:0];
				REG_TOL:   tol_q   <= pwdata[30:0];
				REG_LIMIT: limit_q <= pwdata[15:0];
				default: begin
					for (int i = 0; i < MAX_TERMS; i++)
						if (paddr[4:2] == 3'(i)) coef_q[i] <= pwdata;
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[4:2]))
			REG_TERMS: prdata = {29'd0, terms_q};
			REG_TOL:   prdata = {1'b0, tol_q};
			REG_LIMIT: prdata = {16'd0, limit_q};
			default: begin
				for (int i = 0; i < MAX_TERMS; i++)
					if (paddr[4:2] == 3'(i)) prdata = coef_q[i];
			end
		endcase
	end

	// coefficient pick
	logic signed [31:0] c_km1;
	logic [TW-1:0] km1;
	assign km1 = k_q - TW'(1);
	always_comb begin
		c_km1 = '0;
		for (int i = 0; i < MAX_TERMS; i++) begin
			if (km1 == TW'(i)) c_km1 = coef_q[i];
		end
	end
	// k*c[k] saturated, small constant factor
	function automatic logic signed [31:0] dcoef(input logic [TW-1:0] k,
		input logic signed [31:0] c);
		return sat32(64'(signed'({1'b0, k})) * 64'(c));
	endfunction

	// shared multiplier
	logic signed [31:0] mul_a;
	logic signed [63:0] prod;
	logic signed [63:0] prod_fl;
	assign mul_a   = phase_q ? dx_q : fx_q;
	assign prod    = 64'(mul_a) * 64'(x_q);
	assign prod_fl = prod >>> 16;

	logic [TW-1:0] n_eff;
	always_comb begin
		if (terms_q == 3'd0) n_eff = TW'(1);
		else if (32'(terms_q) > MAX_TERMS) n_eff = TW'(MAX_TERMS);
		else n_eff = TW'(terms_q);
	end

	logic signed [31:0] x1;
	logic [32:0] step_abs, dx_abs;
	logic signed [32:0] step;
	logic        step_small;
	// quotient saturates before it is taken from x
	assign x1         = sat32(64'(x_q) - 64'(sat32(quo)));
	assign step       = 33'(x1) - 33'(x_q);
	assign step_abs   = step[32] ? 33'(-step) : 33'(step);
	assign dx_abs     = dx_q[31] ? 33'(-33'(dx_q)) : 33'(dx_q);
	assign step_small = step_abs < {2'b0, tol_q};

	assign div_start = (state_q == S_TEST) &&
		!(dx_abs < {2'b0, tol_q} || dx_q == 0);

	// p(x) * 65536, sign kept
	assign div_num = {{16{fx_q[31]}}, fx_q, 16'd0};

	pnr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dx_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign start_guess_ready = (state_q == S_IDLE);
	assign result_valid      = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start_guess_valid) state_q <= S_INIT;
				S_INIT: state_q <= (iter_q == limit_q) ? S_OUT : S_EVAL;
				S_EVAL: if (k_q == TW'(1) && phase_q) state_q <= S_TEST;
					else if (k_q == '0) state_q <= S_TEST;
				S_TEST: state_q <= div_start ? S_DIV : S_OUT;
				S_DIV:  if (div_done) state_q <= S_STEP;
				S_STEP: state_q <= (step_small || iter_q == limit_q) ? S_OUT : S_INIT;
				S_OUT:  if (result_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: in S_EVAL alternate p step (phase 0) and p' step (phase 1)
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q <= start_guess;
				iter_q <= '0;
				n_q <= n_eff;
				stop_cause <= CAUSE_LIMIT;
			end
			S_INIT: begin
				k_q <= n_q - TW'(1);
				fx_q <= '0;
				phase_q <= 1'b0;
				// seed: fx = c[n-1], dx = (n-1)c[n-1] (or 0 for one term)
				for (int i = 0; i < MAX_TERMS; i++)
					if (n_q - TW'(1) == TW'(i)) fx_q <= coef_q[i];
				dx_q <= '0;
				for (int i = 1; i < MAX_TERMS; i++)
					if (n_q - TW'(1) == TW'(i))
						dx_q <= dcoef(TW'(i), coef_q[i]);
				if (iter_q != limit_q) iter_q <= iter_q + 16'd1;
			end
			S_EVAL: begin
				if (k_q != '0) begin
					if (!phase_q) begin
						fx_q <= sat32(64'(sat32(prod_fl)) + 64'(c_km1));
						phase_q <= (k_q > TW'(1));
						if (k_q == TW'(1)) k_q <= '0;
					end else begin
						dx_q <= sat32(64'(sat32(prod_fl)) + 64'(dcoef(km1, c_km1)));
						phase_q <= 1'b0;
						k_q <= km1;
					end
				end
			end
			S_TEST: if (!div_start) stop_cause <= CAUSE_FLAT;
			S_STEP: begin
				x_q <= x1;
				if (step_small) stop_cause <= CAUSE_STEP;
			end
			default: ;
		endcase
	end

	assign root_estimate   = x_q;
	assign iterations_used = iter_q;

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !start_guess_ready) else $error("ready during result");
	a_iter_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> iterations_used <= limit_q) else $error("iterations over limit");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider done out of step");
`endif
endmodule : polynomial_newton_root
`default_nettype wire

### sv/pnr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnr_div
// radix-2 restoring divider, one quotient bit per cycle, signed 64 / 32 bits
// ----------------------------------------------------------------------------
module pnr_div
	import pnr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [31:0] den,
	output logic                    done,
	output logic signed [63:0]      quo
);
	logic [63:0] rem_q, q_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [64:0] trial;
	logic [63:0] shifted;

	assign shifted = {rem_q[62:0], q_q[63]};
	assign trial   = {1'b0, shifted} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num[63] ? 64'(-num) : num;
			d_q   <= den[31] ? 64'(-{{32{den[31]}}, den}) : {32'd0, den};
			neg_q <= num[63] ^ den[31];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? 64'(-q_q) : q_q;

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("done while busy");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> cnt_q == 7'd64) else $error("count not loaded");
`endif
endmodule : pnr_div
`default_nettype wire

### sim/pnr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnr_checker
// watches the register port and both item channels of the root finder,
// predicts every result from its own copy of the registers and compares
// ----------------------------------------------------------------------------
module pnr_checker
	import pnr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	input  wire logic               start_guess_valid,
	input  wire logic               start_guess_ready,
	input  wire logic signed [31:0] start_guess,
	input  wire logic               result_valid,
	input  wire logic               result_ready,
	input  wire logic signed [31:0] root_estimate,
	input  wire logic [1:0]         stop_cause,
	input  wire logic [15:0]        iterations_used,
	output int                      errors,
	output int                      pending
);

	typedef struct {
		logic signed [31:0] root;
		cause_t             cause;
		logic [15:0]        used;
	} root_result_t;

	logic signed [31:0] coef [5];
	logic [2:0]         terms;
	logic [30:0]        tol;
	logic [15:0]        limit;
	root_result_t       roots_due [$];

	function automatic logic signed [31:0] clip(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// product floors toward minus infinity, then saturates
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip(p >>> 16);
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clip(longint'(a) + longint'(b));
	endfunction

	function automatic root_result_t newton_solve(input logic signed [31:0] g);
		root_result_t       r;
		logic signed [31:0] x, x1, fx, dx, q;
		longint             thr, mag;
		int                 n, k, it;
		n = terms;
		if (n < 1) n = 1;
		if (n > 5) n = 5;
		thr = longint'(tol);
		x = g;
		r.cause = CAUSE_LIMIT;
		r.used = limit;
		for (it = 0; it < int'(limit); it++) begin
			fx = coef[n-1];
			for (k = n - 1; k > 0; k--) fx = qadd(qmul(fx, x), coef[k-1]);
			if (n < 2) dx = '0;
			else begin
				dx = clip(longint'(n - 1) * longint'(coef[n-1]));
				for (k = n - 1; k > 1; k--)
					dx = qadd(qmul(dx, x), clip(longint'(k - 1) * longint'(coef[k-1])));
			end
			mag = (dx < 0) ? -longint'(dx) : longint'(dx);
			// flat slope, zero slope with zero tolerance included
			if (mag < thr || dx == 0) begin
				r.cause = CAUSE_FLAT;
				r.used = 16'(it + 1);
				break;
			end
			q = clip((longint'(fx) * 65536) / longint'(dx));
			x1 = clip(longint'(x) - longint'(q));
			mag = longint'(x1) - longint'(x);
			if (mag < 0) mag = -mag;
			if (mag < thr) begin
				x = x1;
				r.cause = CAUSE_STEP;
				r.used = 16'(it + 1);
				break;
			end
			x = x1;
		end
		r.root = x;
		return r;
	endfunction

	assign pending = roots_due.size();

	always @(posedge clk or negedge arst_n) begin
		root_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) coef[i] <= '0;
			terms <= 3'd5;
			tol <= 31'd66;
			limit <= 16'd100;
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_C0, REG_C1, REG_C2, REG_C3, REG_C4: coef[paddr[4:2]] <= pwdata;
					REG_TERMS: terms <= pwdata[2:0];
					REG_TOL:   tol <= pwdata[30:0];
					REG_LIMIT: limit <= pwdata[15:0];
					default: ;
				endcase
			end
			if (start_guess_valid && start_guess_ready)
				roots_due.insert(roots_due.size(), newton_solve(start_guess));
			if (result_valid && result_ready) begin
				if (roots_due.size() == 0) begin
					$display("%0t: result with none expected: root %h cause %0d used %0d",
						$time, root_estimate, stop_cause, iterations_used);
					errors <= errors + 1;
				end else begin
					e = roots_due.pop_front();
					if (root_estimate !== e.root || stop_cause !== e.cause ||
							iterations_used !== e.used) begin
						$display("%0t: expected root %h cause %0d used %0d, got %h %0d %0d",
							$time, e.root, e.cause, e.used, root_estimate, stop_cause,
							iterations_used);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// random and directed stimulus for the newton root finder, register phases
// ----------------------------------------------------------------------------
// Register settings change between phases while the block is idle; guesses
// flow with random gaps on both channels, a checker predicts every result.
module tb;
	import pnr_pkg::*;

	logic               clk, arst_n;
	logic               psel, penable, pwrite, pready;
	logic [4:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               start_guess_valid, start_guess_ready;
	logic signed [31:0] start_guess;
	logic               result_valid, result_ready;
	logic signed [31:0] root_estimate;
	logic [1:0]         stop_cause;
	logic [15:0]        iterations_used;
	int                 errors, pending;
	int                 send_idle, recv_idle, hold_cycles;

	polynomial_newton_root DUT (.*);

	pnr_checker chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stalls, or one long counted hold
	initial begin
		result_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ready = 0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			result_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic push_guess(input logic signed [31:0] g);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			start_guess_valid = 0;
			@(negedge clk);
		end
		start_guess_valid = 1;
		start_guess = g;
		do @(posedge clk); while (!start_guess_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		start_guess_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] c0, c1, c2, c3, c4,
			input logic [2:0] n, input logic [30:0] t, input logic [15:0] lim);
		drain();
		reg_write(REG_C0, c0);
		reg_write(REG_C1, c1);
		reg_write(REG_C2, c2);
		reg_write(REG_C3, c3);
		reg_write(REG_C4, c4);
		reg_write(REG_TERMS, {29'd0, n});
		reg_write(REG_TOL, {1'b0, t});
		reg_write(REG_LIMIT, {16'd0, lim});
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(32'h80000) - 32'h40000;
		endcase
	endfunction

	function automatic logic [31:0] rand_guess();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(32'h100000) - 32'h80000;
		endcase
	endfunction

	function automatic logic [30:0] rand_tol();
		case ($urandom_range(5))
			0: return '0;
			1: return 31'($urandom);
			default: return 31'($urandom_range(2000));
		endcase
	endfunction

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start_guess_valid = 0; start_guess = '0;
		send_idle = 9; recv_idle = 48; hold_cycles = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: all coefficients zero, slope is zero
		push_guess(32'sh0);
		push_guess(32'sh7fffffff);
		push_guess(32'sh80000000);
		// x - 3, converges quickly
		set_regs(32'hfffd0000, 32'h00010000, 0, 0, 0, 3'd2, 31'd66, 16'd8);
		push_guess(32'sh0);
		push_guess(32'sh7fffffff);
		push_guess(32'sh80000000);
		// x^2 - 2
		set_regs(32'hfffe0000, 0, 32'h00010000, 0, 0, 3'd3, 31'd66, 16'd20);
		push_guess(32'sh00010000);
		push_guess(32'shfff00000);
		push_guess(32'sh0);
		// saturating quartic, zero tolerance
		set_regs(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			3'd5, 31'd0, 16'd6);
		push_guess(32'sh00020000);
		push_guess(32'sh7fffffff);
		push_guess(32'sh80000000);
		// term count zero acts as one, widest limit and tolerance
		set_regs(32'h7fffffff, 32'h12345678, 0, 0, 0, 3'd0, 31'h7fffffff, 16'hffff);
		push_guess(32'sh00050000);
		push_guess(32'sh80000000);
		// term count above five, zero limit
		set_regs(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
			3'd7, 31'd66, 16'd0);
		push_guess(32'sh12345678);
		push_guess(32'sh80000000);
		// one term, zero tolerance: zero slope stays flat
		set_regs(32'h00030000, 0, 0, 0, 0, 3'd1, 31'd0, 16'd5);
		push_guess(32'sh00010000);
		// cubic running into the limit
		set_regs(32'h00010000, 32'h00010000, 0, 32'h00010000, 0, 3'd4, 31'd0, 16'd3);
		push_guess(32'sh00100000);
		push_guess(32'shfff00000);

		for (int ph = 0; ph < 45; ph++) begin
			set_regs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				3'($urandom_range(7)), rand_tol(), 16'($urandom_range(15)));
			if (ph < 15) begin
				send_idle = 9; recv_idle = 48;
			end else if (ph < 30) begin
				send_idle = 48; recv_idle = 9;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			if (ph == 5 || ph == 40) hold_cycles = 3000;
			for (int i = 0; i < 30; i++) push_guess(rand_guess());
		end

		drain();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
